// File: rtl/ckstep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ckstep_pkg;

    localparam int DEF_STEP_BITS   = 10;
    localparam int DEF_VALUE_WIDTH = 64;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_LEN_W  = 12;
    localparam int OUT_DATA_W = 16;
    localparam int LEN_W      = 13;
    localparam int CHUNK_W    = 32;

    localparam logic [LEN_W-1:0] LENGTH_MAX = LEN_W'(4095);

    typedef struct packed {
        logic load;
        logic mul_first;
        logic mul;
        logic add;
        logic small_step;
        logic small_fin;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic one;
        logic below_k;
        logic reach;
        logic ovf;
        logic mul_last;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/collatz_length_k_step_unit.sv
// channel   direction  fields (lowest bit up)
// s_*       in         tdata: start[63:0]
// m_*       out        tdata: seq_length[11:0], zero pad; tuser: overflow
//
// one request at a time; accept, then check for one or zero
// each jump of STEP_BITS steps from 2^STEP_BITS up: table read, one 32-bit chunk multiply per
// cycle (2 for 64-bit values), add and check
// a value below 2^STEP_BITS jumps by table read alone, with no multiply
// sync reset clears the controller; the result register frees the input side
// a stalled result holds m_tvalid and data until m_tready
`timescale 1ns / 1ps
`default_nettype none

module collatz_length_k_step_unit import ckstep_pkg::*; #(
    parameter int STEP_BITS   = DEF_STEP_BITS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // seq_length, zero pad
    output logic [0:0]            m_tuser    // overflow
);

    t_cmd                 cmd;
    t_status              status;
    logic [OUT_LEN_W-1:0] res_len;
    logic                 res_ovf;

    ckstep_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ckstep_dpath #(
        .STEP_BITS   (STEP_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_tdata),
        .i_cmd    (cmd),
        .o_status (status),
        .o_len    (res_len),
        .o_ovf    (res_ovf)
    );

    assign m_tdata = OUT_DATA_W'(res_len);
    assign m_tuser = res_ovf;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result written while output slot busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new request taken while one is in progress");

    a_flag_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[OUT_LEN_W-1:0] == '0))
        else $error("flagged result carries a length");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.add, cmd.small_step, cmd.small_fin, cmd.emit}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: rtl/ckstep_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module ckstep_dpath import ckstep_pkg::*; #(
    parameter int STEP_BITS   = DEF_STEP_BITS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IN_DATA_W-1:0] i_start,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic [OUT_LEN_W-1:0] o_len,
    output logic                 o_ovf
);

    function automatic logic [63:0] pow3(input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < e; i++) begin
            p = p * 64'd3;
        end
        return p;
    endfunction

    localparam int TBL_SIZE = 1 << STEP_BITS;
    localparam int P_W      = $clog2(pow3(STEP_BITS)) + 1;
    localparam int C_W      = $clog2(STEP_BITS + 1);
    localparam int DS_W     = $clog2(2 * STEP_BITS + 1);
    localparam int E_W      = 1 + DS_W + C_W + 2 * P_W;
    localparam int A_VW     = (VALUE_WIDTH > STEP_BITS) ? VALUE_WIDTH - STEP_BITS : 1;
    localparam int NCHUNK   = (A_VW + CHUNK_W - 1) / CHUNK_W;
    localparam int CI_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int AP_W     = NCHUNK * CHUNK_W;
    localparam int A_W      = AP_W + P_W;
    localparam int S_W      = A_W + 1;
    localparam int M_W      = P_W + CHUNK_W;
    localparam logic [CI_W-1:0] CI_TOP = CI_W'(NCHUNK - 1);

    typedef logic [E_W-1:0] t_rom_entry;
    typedef t_rom_entry t_rom [TBL_SIZE];

    function automatic t_rom build_rom();
        t_rom        tab;
        logic [63:0] v;
        logic [63:0] p;
        logic [63:0] d;
        int          left;
        int          c;
        int          ds;
        logic        reach;
        tab[0] = {1'b0, DS_W'(0), C_W'(0), P_W'(0), P_W'(1)};
        for (int i = 1; i < TBL_SIZE; i++) begin
            v    = 64'(i);
            left = STEP_BITS;
            c    = 0;
            while (left != 0 && v != 64'd1) begin
                if (v[0] == 1'b0) begin
                    v = v >> 1;
                end else begin
                    v = v + (v >> 1) + 64'd1;
                    c = c + 1;
                end
                left = left - 1;
            end
            if (v != 64'd1) begin
                p     = pow3(c);
                d     = v;
                ds    = 0;
                reach = 1'b0;
            end else begin
                ds    = STEP_BITS - left + c;
                c     = c + ((left + 1) >> 1);
                d     = ((left & 1) != 0) ? 64'd2 : 64'd1;
                p     = pow3(c);
                reach = 1'b1;
            end
            tab[i] = {reach, DS_W'(ds), C_W'(c), P_W'(d), P_W'(p)};
        end
        return tab;
    endfunction

    localparam t_rom ROM_DATA = build_rom();

    logic [VALUE_WIDTH-1:0] r_t;
    logic [LEN_W-1:0]       r_len;
    logic                   r_ovf;
    logic [A_W-1:0]         r_acc;
    logic [CI_W-1:0]        r_chunk;
    t_rom_entry             r_rom;
    logic [OUT_LEN_W-1:0]   r_len_out;
    logic                   r_ovf_out;

    logic [P_W-1:0]     rom_p;
    logic [P_W-1:0]     rom_d;
    logic [C_W-1:0]     rom_c;
    logic [DS_W-1:0]    rom_ds;
    logic               rom_reach;
    logic [AP_W-1:0]    a_pad;
    logic [CHUNK_W-1:0] a_chunk;
    logic [M_W-1:0]     prod;
    logic [A_W-1:0]     n_acc;
    logic [S_W-1:0]     sum;
    logic [S_W-1:0]     d_wide;
    logic [LEN_W-1:0]   len_k;
    logic [LEN_W-1:0]   len_ds;

    always_comb begin
        rom_p     = r_rom[P_W-1:0];
        rom_d     = r_rom[2*P_W-1:P_W];
        rom_c     = r_rom[2*P_W +: C_W];
        rom_ds    = r_rom[2*P_W+C_W +: DS_W];
        rom_reach = r_rom[E_W-1];
        a_pad     = AP_W'(r_t >> STEP_BITS);
        a_chunk   = a_pad[r_chunk*CHUNK_W +: CHUNK_W];
        prod      = M_W'(rom_p) * M_W'(a_chunk);
        n_acc     = (i_cmd.mul_first ? '0 : (r_acc << CHUNK_W)) + A_W'(prod);
        sum       = S_W'(r_acc) + S_W'(rom_d);
        d_wide    = S_W'(rom_d);
        len_k     = r_len + LEN_W'(STEP_BITS) + LEN_W'(rom_c);
        len_ds    = r_len + LEN_W'(rom_ds);
    end

    // table read, registered
    always_ff @(posedge i_clk) begin
        r_rom <= ROM_DATA[r_t[STEP_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t   <= i_start[VALUE_WIDTH-1:0];
            r_len <= LEN_W'(1);
            r_ovf <= (i_start[VALUE_WIDTH-1:0] == '0);
        end else if (i_cmd.add) begin
            r_t   <= sum[VALUE_WIDTH-1:0];
            r_len <= len_k;
            r_ovf <= ((sum >> VALUE_WIDTH) != '0) || (len_k > LENGTH_MAX);
        end else if (i_cmd.small_step) begin
            r_t   <= VALUE_WIDTH'(rom_d);
            r_len <= len_k;
            r_ovf <= ((d_wide >> VALUE_WIDTH) != '0) || (len_k > LENGTH_MAX);
        end else if (i_cmd.small_fin) begin
            r_len <= len_ds;
            r_ovf <= (len_ds > LENGTH_MAX);
        end
        if (i_cmd.mul) begin
            r_acc <= n_acc;
        end
        if (i_cmd.emit) begin
            r_len_out <= r_ovf ? '0 : r_len[OUT_LEN_W-1:0];
            r_ovf_out <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= CI_TOP;
        end else if (i_cmd.load || i_cmd.add) begin
            r_chunk <= CI_TOP;
        end else if (i_cmd.mul && (r_chunk != '0)) begin
            r_chunk <= r_chunk - CI_W'(1);
        end
    end

    always_comb begin
        o_status.one      = (r_t == VALUE_WIDTH'(1));
        o_status.below_k  = ((r_t >> STEP_BITS) == '0);
        o_status.reach    = rom_reach;
        o_status.ovf      = r_ovf;
        o_status.mul_last = (r_chunk == '0);
    end

    assign o_len = r_len_out;
    assign o_ovf = r_ovf_out;

endmodule

`default_nettype wire

// File: rtl/ckstep_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ckstep_ctrl import ckstep_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_tvalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.ovf || i_status.one) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.below_k && i_status.reach) begin
                    o_cmd.small_fin = 1'b1;
                    n_state         = S_DONE;
                end else if (i_status.below_k) begin
                    o_cmd.small_step = 1'b1;
                    n_state          = S_CHECK;
                end else begin
                    o_cmd.mul       = 1'b1;
                    o_cmd.mul_first = 1'b1;
                    n_state         = i_status.mul_last ? S_ADD : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_status.mul_last ? S_ADD : S_MUL;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CHECK;
            end
            S_DONE: begin
                if (!r_m_tvalid || m_tready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_tvalid;

endmodule

`default_nettype wire
